@@ rtl/ksct_pkg.sv @@
// shared types, constants and codes of the keyed stock counter table
package ksct_pkg;

  localparam int unsigned ENTRIES_DEF  = 64;
  localparam int unsigned KEY_BITS_DEF = 16;

  localparam logic [7:0] MAX_STOCK_RST   = 8'd10;
  localparam logic [6:0] TABLE_LIMIT_RST = 7'd60;

  localparam logic REG_MAX_STOCK   = 1'b0;
  localparam logic REG_TABLE_LIMIT = 1'b1;

  localparam logic [1:0] MODE_ADD     = 2'd0;
  localparam logic [1:0] MODE_REFILL  = 2'd1;
  localparam logic [1:0] MODE_CONSUME = 2'd2;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_DUP     = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_MISSING = 3'd3;
  localparam logic [2:0] ST_EMPTY   = 3'd4;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] item_id;
    logic [15:0] amount;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] stock_after;
  } rsp_t;

  typedef struct packed {
    logic [7:0] max_stock;
    logic [6:0] table_limit;
  } cfg_t;

endpackage

@@ rtl/ksct_cfg.sv @@
// configuration registers behind the apb-style port
module ksct_cfg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output ksct_pkg::cfg_t    cfg_o
);
  import ksct_pkg::*;

  logic [7:0] max_stock_q;
  logic [6:0] table_limit_q;
  logic       wr_en;
  logic       reg_sel;

  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[2];
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_stock_q   <= MAX_STOCK_RST;
      table_limit_q <= TABLE_LIMIT_RST;
    end else if (wr_en) begin
      if (reg_sel == REG_MAX_STOCK) begin
        max_stock_q <= pwdata[7:0];
      end else begin
        table_limit_q <= pwdata[6:0];
      end
    end
  end

  always_comb begin
    if (reg_sel == REG_TABLE_LIMIT) begin
      prdata = {25'd0, table_limit_q};
    end else begin
      prdata = {24'd0, max_stock_q};
    end
  end

  assign cfg_o.max_stock   = max_stock_q;
  assign cfg_o.table_limit = table_limit_q;

endmodule

@@ rtl/ksct_mem.sv @@
// entry store: key and stock per slot, one write and one registered read port
module ksct_mem #(
  parameter int unsigned ENTRIES  = ksct_pkg::ENTRIES_DEF,
  parameter int unsigned KEY_BITS = ksct_pkg::KEY_BITS_DEF,
  localparam int unsigned IdxW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [IdxW-1:0]     waddr_i,
  input  logic [KEY_BITS-1:0] wkey_i,
  input  logic [7:0]          wstock_i,
  input  logic [IdxW-1:0]     raddr_i,
  output logic [KEY_BITS-1:0] rkey_o,
  output logic [7:0]          rstock_o
);
  logic [KEY_BITS+7:0] mem [ENTRIES];
  logic [KEY_BITS+7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= {wkey_i, wstock_i};
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rkey_o   = rdata_q[KEY_BITS+7:8];
  assign rstock_o = rdata_q[7:0];

endmodule

@@ rtl/ksct_engine.sv @@
// search, read-modify-write sequencer and result register
module ksct_engine #(
  parameter int unsigned ENTRIES  = ksct_pkg::ENTRIES_DEF,
  parameter int unsigned KEY_BITS = ksct_pkg::KEY_BITS_DEF,
  localparam int unsigned IdxW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ksct_pkg::cfg_t      cfg_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ksct_pkg::req_t      in_req_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ksct_pkg::rsp_t      out_rsp_o,
  output logic [IdxW-1:0]     mem_raddr_o,
  input  logic [KEY_BITS-1:0] mem_rkey_i,
  input  logic [7:0]          mem_rstock_i,
  output logic                mem_we_o,
  output logic [IdxW-1:0]     mem_waddr_o,
  output logic [KEY_BITS-1:0] mem_wkey_o,
  output logic [7:0]          mem_wstock_o
);
  import ksct_pkg::*;

  localparam int unsigned CntW = $clog2(ENTRIES + 1);
  localparam int unsigned CmpW = (CntW > 7) ? CntW : 7;

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    FINISH
  } state_e;

  state_e              state_q;
  logic [1:0]          mode_q;
  logic [KEY_BITS-1:0] key_q;
  logic [15:0]         amount_q;
  logic [CntW-1:0]     scan_q;
  logic                pend_q;
  logic [IdxW-1:0]     pend_idx_q;
  logic [CntW-1:0]     count_q;
  logic                found_q;
  logic [IdxW-1:0]     slot_q;
  logic [7:0]          stock_q;
  logic                out_vld_q;
  rsp_t                rsp_q;

  logic                match;
  logic                scan_more;
  logic                fire;
  logic                full;
  logic [7:0]          add_stock;
  logic [16:0]         sum;
  logic [7:0]          refill_stock;
  rsp_t                rsp_d;
  logic                wr_en;
  logic                count_inc;
  logic [IdxW-1:0]     wr_addr;
  logic [7:0]          wr_stock;

  assign match       = pend_q && (mem_rkey_i == key_q);
  assign scan_more   = scan_q < count_q;
  assign mem_raddr_o = scan_q[IdxW-1:0];
  assign fire        = (state_q == FINISH) && (!out_vld_q || !out_stall_i);

  assign full = (CmpW'(count_q) >= CmpW'(cfg_i.table_limit)) ||
                (count_q >= CntW'(ENTRIES));

  assign add_stock    = (amount_q > {8'd0, cfg_i.max_stock}) ? cfg_i.max_stock
                                                              : amount_q[7:0];
  assign sum          = {1'b0, amount_q} + {9'd0, stock_q};
  assign refill_stock = (sum > {9'd0, cfg_i.max_stock}) ? cfg_i.max_stock : sum[7:0];

  always_comb begin
    rsp_d.status      = ST_MISSING;
    rsp_d.stock_after = 8'd0;
    wr_en             = 1'b0;
    count_inc         = 1'b0;
    wr_addr           = slot_q;
    wr_stock          = stock_q;
    case (mode_q)
      MODE_ADD: begin
        if (found_q) begin
          rsp_d.status      = ST_DUP;
          rsp_d.stock_after = stock_q;
        end else if (full) begin
          rsp_d.status = ST_FULL;
        end else begin
          rsp_d.status      = ST_OK;
          rsp_d.stock_after = add_stock;
          wr_en             = 1'b1;
          count_inc         = 1'b1;
          wr_addr           = count_q[IdxW-1:0];
          wr_stock          = add_stock;
        end
      end
      MODE_REFILL: begin
        if (found_q) begin
          rsp_d.status      = ST_OK;
          rsp_d.stock_after = refill_stock;
          wr_en             = 1'b1;
          wr_stock          = refill_stock;
        end
      end
      MODE_CONSUME: begin
        if (found_q) begin
          if (stock_q != 8'd0) begin
            rsp_d.status      = ST_OK;
            rsp_d.stock_after = stock_q - 8'd1;
            wr_en             = 1'b1;
            wr_stock          = stock_q - 8'd1;
          end else begin
            rsp_d.status = ST_EMPTY;
          end
        end
      end
      default: begin
        rsp_d.status = ST_MISSING;
      end
    endcase
  end

  assign mem_we_o     = fire && wr_en;
  assign mem_waddr_o  = wr_addr;
  assign mem_wkey_o   = key_q;
  assign mem_wstock_o = wr_stock;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= IDLE;
      count_q   <= '0;
      out_vld_q <= 1'b0;
      pend_q    <= 1'b0;
      found_q   <= 1'b0;
      scan_q    <= '0;
    end else begin
      if (out_vld_q && !out_stall_i && !fire) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        IDLE: begin
          if (in_valid_i) begin
            mode_q   <= in_req_i.mode;
            key_q    <= KEY_BITS'(in_req_i.item_id);
            amount_q <= in_req_i.amount;
            scan_q   <= '0;
            pend_q   <= 1'b0;
            found_q  <= 1'b0;
            state_q  <= (count_q == '0) ? FINISH : SCAN;
          end
        end
        SCAN: begin
          if (scan_more) begin
            scan_q     <= scan_q + 1'b1;
            pend_idx_q <= scan_q[IdxW-1:0];
            pend_q     <= 1'b1;
          end else begin
            pend_q <= 1'b0;
          end
          if (match) begin
            found_q <= 1'b1;
            slot_q  <= pend_idx_q;
            stock_q <= mem_rstock_i;
            state_q <= FINISH;
          end else if (pend_q && !scan_more) begin
            state_q <= FINISH;
          end
        end
        FINISH: begin
          if (fire) begin
            out_vld_q <= 1'b1;
            rsp_q     <= rsp_d;
            if (count_inc) begin
              count_q <= count_q + 1'b1;
            end
            state_q <= IDLE;
          end
        end
        default: begin
          state_q <= IDLE;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != IDLE);
  assign out_valid_o = out_vld_q;
  assign out_rsp_o   = rsp_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(ENTRIES))
    else $error("entry count above table depth");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> (count_q == $past(count_q) + 1'b1))
    else $error("entry count moved by other than one");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> ($past(state_q) == FINISH))
    else $error("result raised outside finish");

  a_write_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we_o |=> (state_q == IDLE))
    else $error("store written without completing the transaction");

endmodule

@@ rtl/keyed_stock_counter_table_core.sv @@
// top level of the keyed stock counter table
// an item is taken only while the sequencer is idle; the search reads one slot a cycle
// each request is registered in idle; the scan then reads the valid slots in order until a key
// matches or all are read (it is skipped with no entries), and finish registers the result
// a waiting result holds only the final step, so the next search runs meanwhile
// reset clears the entry count, the result valid and the sequencer and loads register defaults

module keyed_stock_counter_table_core #(
  parameter int unsigned ENTRIES  = ksct_pkg::ENTRIES_DEF,
  parameter int unsigned KEY_BITS = ksct_pkg::KEY_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  ksct_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output ksct_pkg::rsp_t out_rsp_o,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);
  import ksct_pkg::*;

  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  cfg_t                cfg;
  logic [IdxW-1:0]     mem_raddr;
  logic [KEY_BITS-1:0] mem_rkey;
  logic [7:0]          mem_rstock;
  logic                mem_we;
  logic [IdxW-1:0]     mem_waddr;
  logic [KEY_BITS-1:0] mem_wkey;
  logic [7:0]          mem_wstock;

  ksct_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ksct_mem #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS)
  ) u_mem (
    .clk_i    (clk_i),
    .we_i     (mem_we),
    .waddr_i  (mem_waddr),
    .wkey_i   (mem_wkey),
    .wstock_i (mem_wstock),
    .raddr_i  (mem_raddr),
    .rkey_o   (mem_rkey),
    .rstock_o (mem_rstock)
  );

  ksct_engine #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_req_i     (in_req_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_rsp_o    (out_rsp_o),
    .mem_raddr_o  (mem_raddr),
    .mem_rkey_i   (mem_rkey),
    .mem_rstock_i (mem_rstock),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wkey_o   (mem_wkey),
    .mem_wstock_o (mem_wstock)
  );

endmodule
